// File: hw/rtl/aik_pkg.sv
// ----------------------------------------------------------------------------
// aik_pkg
// Types, constants and arithmetic helpers for the arm inverse kinematics
// pipeline: stage schedule, CORDIC angle table, integer square root step.
// ----------------------------------------------------------------------------
package aik_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES   = 16;
    localparam int ATAN_LEN        = 24;

    // register indexes on the config port
    localparam logic REG_UPPER_ARM = 1'b0;
    localparam logic REG_FOREARM   = 1'b1;

    localparam logic [8:0] UPPER_ARM_RESET = 9'd300;
    localparam logic [8:0] FOREARM_RESET   = 9'd210;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam longint unsigned ATAN_Q30 [ATAN_LEN] = '{
        64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159,
        64'd67021687,  64'd33543516,  64'd16775851,  64'd8388437,
        64'd4194283,   64'd2097149,   64'd1048576,   64'd524288,
        64'd262144,    64'd131072,    64'd65536,     64'd32768,
        64'd16384,     64'd8192,      64'd4096,      64'd2048,
        64'd1024,      64'd512,       64'd256,       64'd128
    };

    // Q30 angle rounded half up to the output scale
    function automatic logic signed [17:0] q30_ang(input longint unsigned t);
        return 18'((t + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS));
    endfunction

    localparam logic signed [17:0] PI_ANG      = q30_ang(PI_Q30);
    localparam logic signed [17:0] HALF_PI_ANG = q30_ang(PI_Q30 / 2);

    // stage schedule: step k turns pipe_reg[k] into pipe_reg[k+1]
    localparam int ST_SQUARE   = 0;
    localparam int ST_SUM      = 1;
    localparam int ST_N1       = 2;
    localparam int ST_MAG1     = 3;
    localparam int ST_P1       = 4;
    localparam int ST_RAD1     = 5;
    localparam int SQR_FIRST   = 2;
    localparam int SQR_ITERS   = 15;
    localparam int BASE_FIRST  = 2;
    localparam int ST_ELEV_PRE = SQR_FIRST + SQR_ITERS;
    localparam int ELEV_FIRST  = ST_ELEV_PRE + 1;
    localparam int ST_MAG2     = ST_ELEV_PRE + 1;
    localparam int ST_P2       = ST_MAG2 + 1;
    localparam int ST_RAD2     = ST_P2 + 1;
    localparam int SQ1_FIRST   = ST_RAD1 + 1;
    localparam int SQ1_ITERS   = 27;
    localparam int SQ2_FIRST   = ST_RAD2 + 1;
    localparam int SQ2_ITERS   = 29;
    localparam int ST_BETA_PRE = SQ1_FIRST + SQ1_ITERS;
    localparam int BETA_FIRST  = ST_BETA_PRE + 1;
    localparam int ST_GAM_PRE  = SQ2_FIRST + SQ2_ITERS;
    localparam int GAM_FIRST   = ST_GAM_PRE + 1;
    localparam int ST_FINAL    = GAM_FIRST + CORDIC_STAGES;
    localparam int PIPE_LAST   = ST_FINAL + 1;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [17:0] z;
        logic               zero;
    } cord_t;

    typedef struct packed {
        logic [59:0] n;
        logic [59:0] res;
    } sq_t;

    // values derived from the link lengths
    typedef struct packed {
        logic [25:0] a2;
        logic [25:0] b2;
        logic [26:0] d1;
        logic [53:0] d1sq;
        logic [13:0] b32;
    } cfgd_t;

    typedef struct packed {
        logic               valid;
        logic               flag;
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic signed [14:0] z;
        logic [28:0]        xx;
        logic [28:0]        yy;
        logic [28:0]        zz;
        logic [29:0]        r2;
        logic [29:0]        lg2;
        logic [29:0]        sr_n;
        logic [29:0]        sr_res;
        logic [29:0]        sl_n;
        logic [29:0]        sl_res;
        logic signed [31:0] n1;
        logic [26:0]        mag1;
        logic               neg1;
        logic [53:0]        s1_n;
        logic [53:0]        s1_res;
        logic signed [31:0] n2;
        logic [28:0]        d2;
        logic [28:0]        mag2;
        logic               neg2;
        logic [57:0]        s2_n;
        logic [57:0]        s2_res;
        cord_t              cb;
        cord_t              ce;
        cord_t              cbt;
        cord_t              cg;
        logic [15:0]        base_o;
        logic [15:0]        shoulder_o;
        logic [15:0]        elbow_o;
    } pipe_t;

    function automatic logic signed [17:0] atan_ang(input int i);
        return q30_ang(ATAN_Q30[i]);
    endfunction

    // one digit of the floor square root, bit = 4^j
    function automatic sq_t sq_step(input logic [59:0] n, input logic [59:0] res,
                                    input int j);
        logic [59:0] bitv;
        logic [59:0] sum;
        sq_t         o;
        bitv = 60'd1 << (2 * j);
        sum  = res + bitv;
        if (n >= sum) begin
            o.n   = n - sum;
            o.res = (res >> 1) + bitv;
        end else begin
            o.n   = n;
            o.res = res >> 1;
        end
        return o;
    endfunction

    // atan2(yv, xv) setup: quarter turn when x is negative
    function automatic cord_t cordic_pre(input logic signed [32:0] yv,
                                         input logic signed [32:0] xv);
        cord_t o;
        o.zero = (xv == 33'sd0) && (yv == 33'sd0);
        o.x    = xv;
        o.y    = yv;
        o.z    = 18'sd0;
        if (xv < 33'sd0) begin
            if (yv >= 33'sd0) begin
                o.x = yv;
                o.y = -xv;
                o.z = HALF_PI_ANG;
            end else begin
                o.x = -yv;
                o.y = xv;
                o.z = -HALF_PI_ANG;
            end
        end
        return o;
    endfunction

    // one vectoring micro-rotation
    function automatic cord_t cordic_step(input cord_t c, input int i);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        cord_t              o;
        dx = c.y >>> i;
        dy = c.x >>> i;
        o  = c;
        if (c.y > 33'sd0) begin
            o.x = c.x + dx;
            o.y = c.y - dy;
            o.z = c.z + atan_ang(i);
        end else begin
            o.x = c.x - dx;
            o.y = c.y + dy;
            o.z = c.z - atan_ang(i);
        end
        return o;
    endfunction

    function automatic logic signed [17:0] cordic_angle(input cord_t c);
        return c.zero ? 18'sd0 : c.z;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        logic [15:0] o;
        if (v > 20'sd32767) begin
            o = 16'h7fff;
        end else if (v < -20'sd32768) begin
            o = 16'h8000;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

    // clamp |n| to d; flag on clamp or zero denominator
    function automatic logic [32:0] clamp_mag(input logic signed [31:0] n,
                                              input logic [31:0] d);
        logic [31:0] av;
        logic        fl;
        av = n[31] ? 32'(-n) : 32'(n);
        fl = (d == 32'd0);
        if (av > d) begin
            av = d;
            fl = 1'b1;
        end
        return {fl, av};
    endfunction

    // the work of one pipeline step
    function automatic pipe_t do_stage(input int k, input pipe_t s, input cfgd_t c);
        pipe_t       o;
        sq_t         st;
        logic [32:0] cm;
        logic signed [32:0] bx;
        logic signed [17:0] ang_e;
        logic signed [17:0] ang_g;
        logic signed [17:0] ang_b;
        logic signed [19:0] sh;
        logic signed [19:0] el;
        o = s;
        if (k == ST_SQUARE) begin
            o.xx = 29'(s.x * s.x);
            o.yy = 29'(s.y * s.y);
            o.zz = 29'(s.z * s.z);
        end
        if (k == ST_SUM) begin
            o.r2     = 30'(s.xx) + 30'(s.yy);
            o.lg2    = 30'(s.xx) + 30'(s.yy) + 30'(s.zz);
            o.sr_n   = o.r2;
            o.sr_res = 30'd0;
            o.sl_n   = o.lg2;
            o.sl_res = 30'd0;
            o.cb     = cordic_pre(33'(s.x), 33'(s.y));
        end
        if (k == ST_N1) begin
            o.n1 = $signed({6'd0, c.a2}) + $signed({6'd0, c.b2}) - $signed({2'd0, s.lg2});
        end
        if (k == ST_MAG1) begin
            cm     = clamp_mag(s.n1, {5'd0, c.d1});
            o.mag1 = cm[26:0];
            o.neg1 = s.n1[31];
            o.flag = s.flag | cm[32];
        end
        if (k == ST_P1) begin
            o.s1_n = 54'(s.mag1 * s.mag1);
        end
        if (k == ST_RAD1) begin
            o.s1_n   = c.d1sq - s.s1_n;
            o.s1_res = 54'd0;
        end
        // square roots of r^2 and lg^2
        if (k >= SQR_FIRST && k < SQR_FIRST + SQR_ITERS) begin
            st       = sq_step(60'(s.sr_n), 60'(s.sr_res), SQR_FIRST + SQR_ITERS - 1 - k);
            o.sr_n   = 30'(st.n);
            o.sr_res = 30'(st.res);
            st       = sq_step(60'(s.sl_n), 60'(s.sl_res), SQR_FIRST + SQR_ITERS - 1 - k);
            o.sl_n   = 30'(st.n);
            o.sl_res = 30'(st.res);
        end
        if (k >= BASE_FIRST && k < BASE_FIRST + CORDIC_STAGES) begin
            o.cb = cordic_step(s.cb, k - BASE_FIRST);
        end
        // elevation setup, gamma numerator and denominator
        if (k == ST_ELEV_PRE) begin
            o.ce = cordic_pre(33'(s.z), $signed({18'd0, s.sr_res[14:0]}));
            o.d2 = 29'(c.b32 * s.sl_res[14:0]);
            o.n2 = $signed({6'd0, c.b2}) + $signed({2'd0, s.lg2}) - $signed({6'd0, c.a2});
        end
        if (k >= ELEV_FIRST && k < ELEV_FIRST + CORDIC_STAGES) begin
            o.ce = cordic_step(s.ce, k - ELEV_FIRST);
        end
        if (k == ST_MAG2) begin
            cm     = clamp_mag(s.n2, {3'd0, s.d2});
            o.mag2 = cm[28:0];
            o.neg2 = s.n2[31];
            o.flag = s.flag | cm[32];
        end
        if (k == ST_P2) begin
            o.s2_n   = 58'(s.mag2 * s.mag2);
            o.s2_res = 58'(s.d2 * s.d2);
        end
        if (k == ST_RAD2) begin
            o.s2_n   = s.s2_res - s.s2_n;
            o.s2_res = 58'd0;
        end
        if (k >= SQ1_FIRST && k < SQ1_FIRST + SQ1_ITERS) begin
            st       = sq_step(60'(s.s1_n), 60'(s.s1_res), SQ1_FIRST + SQ1_ITERS - 1 - k);
            o.s1_n   = 54'(st.n);
            o.s1_res = 54'(st.res);
        end
        if (k >= SQ2_FIRST && k < SQ2_FIRST + SQ2_ITERS) begin
            st       = sq_step(60'(s.s2_n), 60'(s.s2_res), SQ2_FIRST + SQ2_ITERS - 1 - k);
            o.s2_n   = 58'(st.n);
            o.s2_res = 58'(st.res);
        end
        // beta = acos via atan2(sqrt(d^2 - n^2), n)
        if (k == ST_BETA_PRE) begin
            bx    = $signed({6'd0, s.mag1});
            o.cbt = cordic_pre($signed({6'd0, s.s1_res[26:0]}), s.neg1 ? -bx : bx);
        end
        if (k >= BETA_FIRST && k < BETA_FIRST + CORDIC_STAGES) begin
            o.cbt = cordic_step(s.cbt, k - BETA_FIRST);
        end
        if (k == ST_GAM_PRE) begin
            bx   = $signed({4'd0, s.mag2});
            o.cg = cordic_pre($signed({4'd0, s.s2_res[28:0]}), s.neg2 ? -bx : bx);
        end
        if (k >= GAM_FIRST && k < GAM_FIRST + CORDIC_STAGES) begin
            o.cg = cordic_step(s.cg, k - GAM_FIRST);
        end
        // combine angles and saturate
        if (k == ST_FINAL) begin
            ang_e        = cordic_angle(s.ce);
            ang_g        = cordic_angle(s.cg);
            ang_b        = cordic_angle(s.cbt);
            el           = 20'(PI_ANG) - 20'(ang_b);
            sh           = 20'(ang_e) + el - 20'(ang_g);
            o.base_o     = sat16(20'(cordic_angle(s.cb)));
            o.shoulder_o = sat16(sh);
            o.elbow_o    = sat16(el);
        end
        return o;
    endfunction

endpackage

// File: hw/rtl/arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// arm_inverse_kinematics
// Joint angles of a turning-base, two-link arm from a target point.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per target point, x/y/z in signed Q11.4 mm.
//   Master channel m_*: one result per request, base, shoulder and elbow
//   angles in signed Q3.13 rad, plus an out-of-reach flag in m_tuser.
//   Config port: cfg_wr_en/cfg_addr/cfg_wdata set the upper arm (index 0)
//   and forearm (index 1) lengths in whole mm; write only while idle.
// Timing:
//   A request is taken every cycle unless the pipeline holds (Backpressure).
//   The gamma path is the longest: 2 square/sum steps, 15 root digits of lg^2,
//   4 setup steps, 29 root digits, CORDIC setup, 16 rotations, combine.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and loads the
//   lengths 300 mm and 210 mm.
// Backpressure:
//   While m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module arm_inverse_kinematics (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_wdata,
    // target request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // target_x[14:0], target_y[29:15], target_z[44:30]
    // angle result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // base_angle[15:0], shoulder_angle[31:16],
                                   // elbow_angle[47:32]
    output logic        m_tuser    // unreachable
);

    logic [8:0]  upper_len_reg;
    logic [8:0]  fore_len_reg;
    logic [25:0] a2_reg;
    logic [25:0] b2_reg;
    logic [17:0] ab_reg;
    logic [53:0] d1sq_reg;
    logic [26:0] d1;
    aik_pkg::cfgd_t cfgd;

    aik_pkg::pipe_t pipe_reg  [aik_pkg::PIPE_LAST+1];
    aik_pkg::pipe_t pipe_next [aik_pkg::PIPE_LAST];
    aik_pkg::pipe_t pipe_in;
    logic           adv;

    // link length registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= aik_pkg::UPPER_ARM_RESET;
            fore_len_reg  <= aik_pkg::FOREARM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                aik_pkg::REG_UPPER_ARM: upper_len_reg <= cfg_wdata;
                aik_pkg::REG_FOREARM:   fore_len_reg  <= cfg_wdata;
                default:                upper_len_reg <= upper_len_reg;
            endcase
        end
    end

    // derived length terms, registered from the length registers; d1sq is registered from d1
    assign d1 = {ab_reg, 9'd0};

    always_ff @(posedge aclk) begin
        a2_reg   <= {18'(upper_len_reg * upper_len_reg), 8'd0};
        b2_reg   <= {18'(fore_len_reg * fore_len_reg), 8'd0};
        ab_reg   <= 18'(upper_len_reg * fore_len_reg);
        d1sq_reg <= 54'(d1 * d1);
    end

    always_comb begin
        cfgd.a2   = a2_reg;
        cfgd.b2   = b2_reg;
        cfgd.d1   = d1;
        cfgd.d1sq = d1sq_reg;
        cfgd.b32  = {fore_len_reg, 5'd0};
    end

    // pipeline moves as one; the last stage is the output register
    assign adv      = !pipe_reg[aik_pkg::PIPE_LAST].valid || m_tready;
    assign s_tready = adv;

    always_comb begin
        pipe_in       = '0;
        pipe_in.valid = s_tvalid;
        pipe_in.x     = s_tdata[14:0];
        pipe_in.y     = s_tdata[29:15];
        pipe_in.z     = s_tdata[44:30];
    end

    for (genvar k = 0; k < aik_pkg::PIPE_LAST; k++) begin : g_step
        assign pipe_next[k] = aik_pkg::do_stage(k, pipe_reg[k], cfgd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= aik_pkg::PIPE_LAST; k++) begin
                pipe_reg[k].valid <= 1'b0;
            end
        end else if (adv) begin
            pipe_reg[0] <= pipe_in;
            for (int k = 0; k < aik_pkg::PIPE_LAST; k++) begin
                pipe_reg[k+1] <= pipe_next[k];
            end
        end
    end

    // result channel
    assign m_tvalid = pipe_reg[aik_pkg::PIPE_LAST].valid;
    assign m_tdata  = {pipe_reg[aik_pkg::PIPE_LAST].elbow_o,
                       pipe_reg[aik_pkg::PIPE_LAST].shoulder_o,
                       pipe_reg[aik_pkg::PIPE_LAST].base_o};
    assign m_tuser  = pipe_reg[aik_pkg::PIPE_LAST].flag;

endmodule
